// ===== sv/irclt_pkg.sv =====
package irclt_pkg;

    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_SP    = 8'h20;
    localparam logic [7:0] BYTE_COLON = 8'h3A;
    localparam logic [7:0] BYTE_LC_A  = 8'h61;
    localparam logic [7:0] BYTE_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int TUSER_W = 6;

    typedef enum logic [1:0] {
        REGION_CMD   = 2'd0,
        REGION_PARAM = 2'd1,
        REGION_TRAIL = 2'd2
    } region_t;

    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_PARAM = 2'd1;
    localparam logic [1:0] KIND_TRAIL = 2'd2;

    typedef struct packed {
        region_t region;
        logic    inside_token;
        logic    last_was_space;
    } tok_state_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic [1:0] token_kind;
        logic       token_start;
        logic       line_end;
        logic       has_trailing;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic       emit;
        result_t    res;
        tok_state_t st;
    } take_t;

endpackage

// ===== sv/irc_line_tokenizer.sv =====
// Line tokenizer for chat-protocol message lines. Takes one received byte per
// input word (s_tdata) and returns tagged token characters and line-end marks
// on the output stream: m_tdata carries the character, m_tuser the flags and
// token kind, m_tlast marks the last output word caused by one input byte.
// CR LF ends a line; a CR is held back until the next byte shows whether it
// belongs to CR LF, so a lone CR followed by a byte may yield two output words.
// Whitespace before the trailing part separates tokens and is dropped; the
// first token is the command (a to z upper-cased), later ones are parameters;
// a colon right after a space opens the trailing part, which passes literally.
// One input byte is accepted every cycle while the result queue has room; the
// byte is registered in the input register, and its results pass through a
// four-entry result queue to the output. Throughput is set by the output port,
// one word per cycle while m_tready is high.
module irc_line_tokenizer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // data_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // out_char
    output logic [irclt_pkg::TUSER_W-1:0] m_tuser,   // char_valid, token_kind[1:0],
                                                     // token_start, line_end, has_trailing
    output logic                          m_tlast    // last_of_run
);

    function automatic logic is_sep(logic [7:0] b);
        return (b == irclt_pkg::BYTE_SP) ||
               ((b >= irclt_pkg::BYTE_TAB) && (b <= irclt_pkg::BYTE_CR));
    endfunction

    function automatic irclt_pkg::take_t take_byte(irclt_pkg::tok_state_t st,
                                                    logic [7:0] b);
        irclt_pkg::take_t t;
        t.emit = 1'b0;
        t.res  = '0;
        t.st   = st;
        if (st.region == irclt_pkg::REGION_TRAIL)
        begin
            t.emit             = 1'b1;
            t.res.char_valid   = 1'b1;
            t.res.out_char     = b;
            t.res.token_kind   = irclt_pkg::KIND_TRAIL;
            t.res.token_start  = !st.inside_token;
            t.st.inside_token  = 1'b1;
        end
        else if ((b == irclt_pkg::BYTE_COLON) && st.last_was_space)
        begin
            t.st.region         = irclt_pkg::REGION_TRAIL;
            t.st.inside_token   = 1'b0;
            t.st.last_was_space = 1'b0;
        end
        else
        begin
            t.st.last_was_space = (b == irclt_pkg::BYTE_SP);
            if (is_sep(b))
            begin
                if (st.inside_token && (st.region == irclt_pkg::REGION_CMD))
                    t.st.region = irclt_pkg::REGION_PARAM;
                t.st.inside_token = 1'b0;
            end
            else
            begin
                t.emit            = 1'b1;
                t.res.char_valid  = 1'b1;
                t.res.token_start = !st.inside_token;
                t.st.inside_token = 1'b1;
                if (st.region == irclt_pkg::REGION_CMD)
                begin
                    t.res.token_kind = irclt_pkg::KIND_CMD;
                    if ((b >= irclt_pkg::BYTE_LC_A) && (b <= irclt_pkg::BYTE_LC_Z))
                        t.res.out_char = b & ~irclt_pkg::CASE_BIT;
                    else
                        t.res.out_char = b;
                end
                else
                begin
                    t.res.token_kind = irclt_pkg::KIND_PARAM;
                    t.res.out_char   = b;
                end
            end
        end
        return t;
    endfunction

    // input register
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;

    // tokenizer state
    irclt_pkg::tok_state_t state_reg, state_next;
    logic                  cr_held_reg, cr_held_next;

    // result queue
    irclt_pkg::result_t               q_reg [irclt_pkg::QDEPTH];
    logic [irclt_pkg::QPTR_W-1:0]     head_reg, tail_reg;
    logic [irclt_pkg::QCNT_W-1:0]     count_reg;

    irclt_pkg::take_t   take_cr, take_in;
    irclt_pkg::result_t res0, res1;
    logic [1:0]         n_res;
    logic               pop;
    logic               room;
    logic               consume;
    logic [irclt_pkg::QCNT_W:0] avail;

    always_comb
    begin
        take_cr      = '0;
        take_in      = '0;
        res0         = '0;
        res1         = '0;
        n_res        = 2'd0;
        state_next   = state_reg;
        cr_held_next = 1'b0;
        if (cr_held_reg && (in_byte_reg == irclt_pkg::BYTE_LF))
        begin
            res0.line_end     = 1'b1;
            res0.has_trailing = (state_reg.region == irclt_pkg::REGION_TRAIL);
            res0.last_of_run  = 1'b1;
            n_res             = 2'd1;
            state_next        = '{irclt_pkg::REGION_CMD, 1'b0, 1'b0};
        end
        else
        begin
            if (cr_held_reg)
                take_cr = take_byte(state_reg, irclt_pkg::BYTE_CR);
            else
                take_cr.st = state_reg;
            if (in_byte_reg == irclt_pkg::BYTE_CR)
            begin
                cr_held_next = 1'b1;
                take_in.st   = take_cr.st;
            end
            else
                take_in = take_byte(take_cr.st, in_byte_reg);
            state_next = take_in.st;
            n_res      = {1'b0, take_cr.emit} + {1'b0, take_in.emit};
            if (take_cr.emit)
            begin
                res0 = take_cr.res;
                res1 = take_in.res;
                if (take_in.emit)
                    res1.last_of_run = 1'b1;
                else
                    res0.last_of_run = 1'b1;
            end
            else
            begin
                res0             = take_in.res;
                res0.last_of_run = take_in.emit;
            end
        end
    end

    assign pop      = (count_reg != '0) && m_tready;
    assign avail    = {1'b0, irclt_pkg::QCNT_W'(irclt_pkg::QDEPTH) - count_reg}
                      + {{irclt_pkg::QCNT_W{1'b0}}, pop};
    assign room     = avail >= (irclt_pkg::QCNT_W + 1)'(n_res);
    assign consume  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '{irclt_pkg::REGION_CMD, 1'b0, 1'b0};
            cr_held_reg  <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (consume)
            begin
                state_reg   <= state_next;
                cr_held_reg <= cr_held_next;
                tail_reg    <= tail_reg + irclt_pkg::QPTR_W'(n_res);
            end
            if (pop)
                head_reg <= head_reg + 1'b1;
            count_reg <= count_reg
                         + (consume ? irclt_pkg::QCNT_W'(n_res) : '0)
                         - irclt_pkg::QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
        if (consume && (n_res != 2'd0))
            q_reg[tail_reg] <= res0;
        if (consume && (n_res == 2'd2))
            q_reg[tail_reg + 1'b1] <= res1;
    end

    irclt_pkg::result_t head_res;
    assign head_res = q_reg[head_reg];

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = head_res.out_char;
    assign m_tuser  = {head_res.has_trailing, head_res.line_end, head_res.token_start,
                       head_res.token_kind, head_res.char_valid};
    assign m_tlast  = head_res.last_of_run;

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= irclt_pkg::QCNT_W'(irclt_pkg::QDEPTH))
        else $error("result queue overflow");

    // a consumed CR is held for the next byte
    assert property (@(posedge clk) disable iff (!rst_n)
        consume && (in_byte_reg == irclt_pkg::BYTE_CR) |=> cr_held_reg)
        else $error("carriage return not held");

    // line end words carry no character and close the run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && head_res.line_end |-> !head_res.char_valid && head_res.last_of_run)
        else $error("malformed line end word");

    // line end returns the tokenizer to the command region
    assert property (@(posedge clk) disable iff (!rst_n)
        consume && cr_held_reg && (in_byte_reg == irclt_pkg::BYTE_LF)
        |=> (state_reg.region == irclt_pkg::REGION_CMD) && !state_reg.inside_token)
        else $error("state not cleared at line end");

endmodule

// ===== tb/irc_line_tokenizer_test.sv =====
module irc_line_tokenizer_test;

    localparam int LIMIT        = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_CYCLES = 300;

    localparam logic [7:0] BYTE_VT = 8'h0B;
    localparam logic [7:0] BYTE_FF = 8'h0C;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [irclt_pkg::TUSER_W-1:0] m_tuser;
    logic       m_tlast;

    irclt_pkg::result_t expected_words [$];
    irclt_pkg::region_t tok_region = irclt_pkg::REGION_CMD;
    logic    in_token   = 1'b0;
    logic    prev_space = 1'b0;
    logic    cr_pending = 1'b0;

    int  errors         = 0;
    int  cycles         = 0;
    int  bytes_sent     = 0;
    int  rx_hold_cycles = 0;
    bit  rx_holding     = 1'b0;
    bit  rx_steady      = 1'b0;
    bit  tx_steady      = 1'b0;

    irc_line_tokenizer dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bit is_separator(input logic [7:0] b);
        return b == irclt_pkg::BYTE_SP
               || (b >= irclt_pkg::BYTE_TAB && b <= irclt_pkg::BYTE_CR);
    endfunction

    function automatic bit take_byte(input logic [7:0] b, output irclt_pkg::result_t r);
        r = '0;
        if (tok_region == irclt_pkg::REGION_TRAIL)
        begin
            r.char_valid  = 1'b1;
            r.out_char    = b;
            r.token_kind  = irclt_pkg::KIND_TRAIL;
            r.token_start = !in_token;
            in_token      = 1'b1;
            return 1'b1;
        end
        if (b == irclt_pkg::BYTE_COLON && prev_space)
        begin
            tok_region = irclt_pkg::REGION_TRAIL;
            in_token   = 1'b0;
            prev_space = 1'b0;
            return 1'b0;
        end
        prev_space = (b == irclt_pkg::BYTE_SP);
        if (is_separator(b))
        begin
            if (in_token && tok_region == irclt_pkg::REGION_CMD)
                tok_region = irclt_pkg::REGION_PARAM;
            in_token = 1'b0;
            return 1'b0;
        end
        r.char_valid  = 1'b1;
        r.token_kind  = (tok_region == irclt_pkg::REGION_CMD)
                        ? irclt_pkg::KIND_CMD : irclt_pkg::KIND_PARAM;
        r.out_char    = (tok_region == irclt_pkg::REGION_CMD
                         && b >= irclt_pkg::BYTE_LC_A && b <= irclt_pkg::BYTE_LC_Z)
                        ? b - irclt_pkg::CASE_BIT : b;
        r.token_start = !in_token;
        in_token      = 1'b1;
        return 1'b1;
    endfunction

    function automatic void queue_word(input irclt_pkg::result_t r);
        expected_words = {expected_words, r};
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b);
        irclt_pkg::result_t w [2];
        irclt_pkg::result_t r;
        int      n;
        n = 0;
        if (cr_pending)
        begin
            cr_pending = 1'b0;
            if (b == irclt_pkg::BYTE_LF)
            begin
                r              = '0;
                r.line_end     = 1'b1;
                r.has_trailing = (tok_region == irclt_pkg::REGION_TRAIL);
                r.last_of_run  = 1'b1;
                queue_word(r);
                tok_region = irclt_pkg::REGION_CMD;
                in_token   = 1'b0;
                prev_space = 1'b0;
                return;
            end
            if (take_byte(irclt_pkg::BYTE_CR, r))
            begin
                w[n] = r;
                n++;
            end
        end
        if (b == irclt_pkg::BYTE_CR)
            cr_pending = 1'b1;
        else if (take_byte(b, r))
        begin
            w[n] = r;
            n++;
        end
        if (n > 0)
            w[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            queue_word(w[i]);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 5))
            3:       return irclt_pkg::BYTE_TAB;
            4:       return BYTE_VT;
            5:       return BYTE_FF;
            default: return irclt_pkg::BYTE_SP;
        endcase
    endfunction

    function automatic logic [7:0] pick_token_char(input bit cmd);
        logic [7:0] c;
        if (cmd && $urandom_range(0, 9) < 7)
        begin
            c = 8'($urandom_range(irclt_pkg::BYTE_LC_A, irclt_pkg::BYTE_LC_Z));
            return $urandom_range(0, 1) ? c : c - irclt_pkg::CASE_BIT;
        end
        do
            c = 8'($urandom_range(0, 255));
        while (is_separator(c));
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int   gap;
        logic rdy;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            if (rdy)
                tokenize_byte(b);
            @(posedge clk);
        end
        while (!rdy);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_line();
        if ($urandom_range(0, 9) == 0)
            send_byte(pick_separator());
        repeat ($urandom_range(1, 6)) send_byte(pick_token_char(1'b1));
        repeat ($urandom_range(0, 4))
        begin
            repeat ($urandom_range(1, 2)) send_byte(pick_separator());
            repeat ($urandom_range(1, 5)) send_byte(pick_token_char(1'b0));
        end
        if ($urandom_range(0, 2) != 0)
        begin
            send_byte(irclt_pkg::BYTE_SP);
            send_byte(irclt_pkg::BYTE_COLON);
            repeat ($urandom_range(0, 10)) send_byte(8'($urandom_range(0, 255)));
        end
        send_byte(irclt_pkg::BYTE_CR);
        send_byte(irclt_pkg::BYTE_LF);
    endtask

    task automatic test_directed_cases();
        logic [7:0] seq [26] = '{8'h60, "z", "a", 8'h7B, irclt_pkg::BYTE_TAB, 8'h00, 8'hFF,
                                 irclt_pkg::BYTE_CR, "x", irclt_pkg::BYTE_SP,
                                 irclt_pkg::BYTE_COLON, irclt_pkg::BYTE_LF,
                                 irclt_pkg::BYTE_CR, irclt_pkg::BYTE_CR, "q",
                                 irclt_pkg::BYTE_CR, irclt_pkg::BYTE_LF,
                                 irclt_pkg::BYTE_SP, irclt_pkg::BYTE_COLON,
                                 irclt_pkg::BYTE_CR, irclt_pkg::BYTE_LF,
                                 irclt_pkg::BYTE_CR, irclt_pkg::BYTE_LF,
                                 irclt_pkg::BYTE_COLON, irclt_pkg::BYTE_CR,
                                 irclt_pkg::BYTE_LF};
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_steady_lines();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (4) send_random_line();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_random_lines();
        while (bytes_sent < 430)
            send_random_line();
    endtask

    // output held off while input keeps coming, so the result queue fills
    task automatic test_receiver_stall();
        s_tvalid <= 1'b0;
        rx_hold_cycles = STALL_CYCLES;
        wait (rx_holding);
        @(posedge clk);
        tx_steady = 1'b1;
        send_byte("p");
        send_byte(irclt_pkg::BYTE_SP);
        send_byte(irclt_pkg::BYTE_COLON);
        repeat (36) send_byte(8'($urandom_range(0, 255)));
        tx_steady = 1'b0;
        send_byte(irclt_pkg::BYTE_CR);
        send_byte(irclt_pkg::BYTE_LF);
    endtask

    task automatic test_pause_until_drained();
        send_random_line();
        wait_drained();
        send_random_line();
    endtask

    task automatic test_noise();
        repeat (60)
        begin
            case ($urandom_range(0, 9))
                0:       send_byte(irclt_pkg::BYTE_CR);
                1:       send_byte(irclt_pkg::BYTE_LF);
                2:       send_byte(irclt_pkg::BYTE_SP);
                3:       send_byte(irclt_pkg::BYTE_COLON);
                4:       send_byte(irclt_pkg::BYTE_TAB);
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
        send_byte(irclt_pkg::BYTE_CR);
        send_byte(irclt_pkg::BYTE_LF);
    endtask

    initial
    begin
        int n;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                n              = rx_hold_cycles;
                rx_hold_cycles = 0;
                rx_holding     = 1'b1;
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
                rx_holding     = 1'b0;
            end
            else if (rx_steady)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic       took;
        logic [7:0] d;
        logic [irclt_pkg::TUSER_W-1:0] u;
        logic       l;
        irclt_pkg::result_t w;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            took = m_tvalid && m_tready;
            d    = m_tdata;
            u    = m_tuser;
            l    = m_tlast;
            @(posedge clk);
            if (took)
            begin
                if (expected_words.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: char %h user %b last %b", d, u, l);
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (d !== w.out_char || u[0] !== w.char_valid
                        || u[2:1] !== w.token_kind || u[3] !== w.token_start
                        || u[4] !== w.line_end || u[5] !== w.has_trailing
                        || l !== w.last_of_run)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected char %h valid %b kind %0d start %b ",
                                      "end %b trail %b last %b, got char %h valid %b kind %0d ",
                                      "start %b end %b trail %b last %b"},
                                     w.out_char, w.char_valid, w.token_kind, w.token_start,
                                     w.line_end, w.has_trailing, w.last_of_run,
                                     d, u[0], u[2:1], u[3], u[4], u[5], l);
                    end
                end
            end
        end
    end

    initial
    begin
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        rst_n    <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_steady_lines();
        test_random_lines();
        test_receiver_stall();
        test_pause_until_drained();
        test_noise();
        wait_drained();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
